// ===== src/iqwos_pkg.sv =====
// Shared types and constants of the issue queue.
package iqwos_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_MAX_WIDTH   = 8;

    localparam int TAG_W   = 6;
    localparam int CLASS_W = 2;
    localparam int CMD_W   = 2;
    localparam int IW_W    = 4;

    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WAKEUP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT   = 2'd2;

    localparam logic [IW_W-1:0] IW_RESET = 4'd4;

    localparam int          ADDR_W         = 3;
    localparam logic [ADDR_W-1:0] ADDR_ISSUE_WIDTH = 3'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic age;
        logic find;
        logic issue;
        logic issue_last;
        logic emit_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic is_select;
        logic found;
        logic other_ready;
    } t_dp_stat;

endpackage

// ===== src/issue_queue_wakeup_oldest_select.sv =====
// Top level of the issue queue with tag wakeup and oldest-first select.
//
//  Channel    Direction  Carries
//  s_axis     in         one request: dispatch, wakeup or select (kind in tuser)
//  m_axis     out        result items; issue_valid in tuser, last in tlast
//  apb        in/out     issue_width register at byte address 0
//
// Dispatch and wakeup are accepted, then executed into the output register.
// A select is accepted, decoded and ages the slots; each issued result then takes a find
// step and a pick step of the two-level registered oldest-first search over the slots.
// Reset is synchronous: all slots free, issue_width back to 4.
// A held result stalls the controller only when the next result is ready to load.
module issue_queue_wakeup_oldest_select #(
    parameter int QUEUE_DEPTH = iqwos_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_WIDTH   = iqwos_pkg::DEF_MAX_WIDTH,
    localparam int SW    = $clog2(QUEUE_DEPTH),
    localparam int FW    = $clog2(QUEUE_DEPTH + 1),
    localparam int OBITS = 1 + iqwos_pkg::TAG_W + iqwos_pkg::CLASS_W + SW + FW,
    localparam int OUT_W = ((OBITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [5:0] dest_tag, [7:6] op_class, [13:8] src1_tag, [14] src1 ready flag,
    // [20:15] src2_tag, [21] src2 ready flag, [27:22] wake_tag
    input  logic [31:0]                   s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] accepted, [6:1] issued_dest, [8:7] issued_class, then issued_slot,
    // then free_count
    output logic [OUT_W-1:0]              m_axis_tdata,
    // [0] issue_valid
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iqwos_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    iqwos_pkg::t_dp_cmd  cmd;
    iqwos_pkg::t_dp_stat stat;

    logic                            acc, iv, last;
    logic [iqwos_pkg::TAG_W-1:0]     dest;
    logic [iqwos_pkg::CLASS_W-1:0]   cls;
    logic [SW-1:0]                   slot;
    logic [FW-1:0]                   free_cnt;

    assign pready = 1'b1;

    iqwos_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    iqwos_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (s_axis_tuser),
        .i_dest_tag     (s_axis_tdata[5:0]),
        .i_op_class     (s_axis_tdata[7:6]),
        .i_src1_tag     (s_axis_tdata[13:8]),
        .i_src1_ok      (s_axis_tdata[14]),
        .i_src2_tag     (s_axis_tdata[20:15]),
        .i_src2_ok      (s_axis_tdata[21]),
        .i_wake_tag     (s_axis_tdata[27:22]),
        .i_out_ready    (m_axis_tready),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (m_axis_tvalid),
        .o_accepted     (acc),
        .o_issue_valid  (iv),
        .o_issued_dest  (dest),
        .o_issued_class (cls),
        .o_issued_slot  (slot),
        .o_free_count   (free_cnt),
        .o_last         (last)
    );

    assign m_axis_tdata = OUT_W'({free_cnt, slot, cls, dest, acc});
    assign m_axis_tuser = iv;
    assign m_axis_tlast = last;

endmodule

// ===== src/iqwos_ctrl.sv =====
// Controller state machine and issue width register of the issue queue.
module iqwos_ctrl #(
    parameter int MAX_WIDTH = iqwos_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tvalid,
    output logic                          o_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iqwos_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    input  iqwos_pkg::t_dp_stat           i_stat,
    output iqwos_pkg::t_dp_cmd            o_cmd
);

    localparam int KW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_AGE  = 5'b00100,
        S_FIND = 5'b01000,
        S_PICK = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [iqwos_pkg::IW_W-1:0] r_iw;
    logic [KW-1:0]             r_k, n_k;
    logic [iqwos_pkg::IW_W:0]  lim_full;
    logic [KW-1:0]             limit;
    logic                      is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw <= iqwos_pkg::IW_RESET;
        end else if (psel && penable && pwrite && paddr == iqwos_pkg::ADDR_ISSUE_WIDTH) begin
            r_iw <= pwdata[iqwos_pkg::IW_W-1:0];
        end
    end

    assign prdata = (paddr == iqwos_pkg::ADDR_ISSUE_WIDTH) ?
                    {{(32 - iqwos_pkg::IW_W){1'b0}}, r_iw} : 32'd0;

    assign lim_full = ({1'b0, r_iw} > (iqwos_pkg::IW_W + 1)'(MAX_WIDTH)) ?
                      (iqwos_pkg::IW_W + 1)'(MAX_WIDTH) : {1'b0, r_iw};
    assign limit    = KW'(lim_full);
    assign is_last  = ((r_k + KW'(1)) == limit) || !i_stat.other_ready;
    assign o_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_select) begin
                    n_state = S_AGE;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_AGE: begin
                o_cmd.age = 1'b1;
                n_k = '0;
                n_state = S_FIND;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state = S_PICK;
            end
            S_PICK: begin
                if (r_k == '0 && (limit == '0 || !i_stat.found)) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.out_free) begin
                    o_cmd.issue      = 1'b1;
                    o_cmd.issue_last = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + KW'(1);
                        n_state = S_FIND;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

endmodule

// ===== src/iqwos_dp.sv =====
// Datapath of the issue queue: slot storage, wakeup, oldest search and output register.
module iqwos_dp #(
    parameter int QUEUE_DEPTH = iqwos_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [iqwos_pkg::CMD_W-1:0]       i_command,
    input  logic [iqwos_pkg::TAG_W-1:0]       i_dest_tag,
    input  logic [iqwos_pkg::CLASS_W-1:0]     i_op_class,
    input  logic [iqwos_pkg::TAG_W-1:0]       i_src1_tag,
    input  logic                              i_src1_ok,
    input  logic [iqwos_pkg::TAG_W-1:0]       i_src2_tag,
    input  logic                              i_src2_ok,
    input  logic [iqwos_pkg::TAG_W-1:0]       i_wake_tag,
    input  logic                              i_out_ready,
    input  iqwos_pkg::t_dp_cmd                i_cmd,
    output iqwos_pkg::t_dp_stat               o_stat,
    output logic                              o_valid,
    output logic                              o_accepted,
    output logic                              o_issue_valid,
    output logic [iqwos_pkg::TAG_W-1:0]       o_issued_dest,
    output logic [iqwos_pkg::CLASS_W-1:0]     o_issued_class,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    o_issued_slot,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_free_count,
    output logic                              o_last
);

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int GS = 4;
    localparam int NG = (QUEUE_DEPTH + GS - 1) / GS;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    logic [QUEUE_DEPTH-1:0]           r_valid;
    logic [15:0]                      r_age  [QUEUE_DEPTH];
    logic [iqwos_pkg::TAG_W-1:0]      r_dest [QUEUE_DEPTH];
    logic [iqwos_pkg::CLASS_W-1:0]    r_cls  [QUEUE_DEPTH];
    logic [iqwos_pkg::TAG_W-1:0]      r_s1   [QUEUE_DEPTH];
    logic [iqwos_pkg::TAG_W-1:0]      r_s2   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]           r_s1ok;
    logic [QUEUE_DEPTH-1:0]           r_s2ok;
    logic [FW-1:0]                    r_free;

    logic [iqwos_pkg::CMD_W-1:0]      r_cmd;
    logic [iqwos_pkg::TAG_W-1:0]      r_in_dest, r_in_s1, r_in_s2, r_in_wake;
    logic [iqwos_pkg::CLASS_W-1:0]    r_in_cls;
    logic                             r_in_s1ok, r_in_s2ok;

    // First level of the oldest search: one winner per group of four slots.
    logic [NG-1:0]                    r_gv;
    logic [15:0]                      r_gage [NG];
    logic [SW-1:0]                    r_gidx [NG];
    logic [NG-1:0]                    n_gv;
    logic [15:0]                      n_gage [NG];
    logic [SW-1:0]                    n_gidx [NG];

    logic                             r_ovalid;
    logic                             r_oacc, r_oiv, r_olast;
    logic [iqwos_pkg::TAG_W-1:0]      r_odest;
    logic [iqwos_pkg::CLASS_W-1:0]    r_ocls;
    logic [SW-1:0]                    r_oslot;
    logic [FW-1:0]                    r_ofree;

    logic [QUEUE_DEPTH-1:0]           rdy;
    logic                             win_v;
    logic [15:0]                      win_age;
    logic [SW-1:0]                    win_idx;
    logic                             other;
    logic [SW-1:0]                    free_idx;
    logic                             full;
    logic                             do_disp;

    assign rdy     = r_valid & r_s1ok & r_s2ok;
    assign full    = (r_free == '0);
    assign do_disp = i_cmd.exec && r_cmd == iqwos_pkg::CMD_DISPATCH && !full;

    always_comb begin
        int idx;
        for (int g = 0; g < NG; g++) begin
            n_gv[g]   = 1'b0;
            n_gage[g] = '0;
            n_gidx[g] = '0;
            for (int j = 0; j < GS; j++) begin
                idx = g * GS + j;
                if (idx < QUEUE_DEPTH) begin
                    if (rdy[idx] && (!n_gv[g] || r_age[idx] > n_gage[g])) begin
                        n_gv[g]   = 1'b1;
                        n_gage[g] = r_age[idx];
                        n_gidx[g] = SW'(idx);
                    end
                end
            end
        end
    end

    always_comb begin
        win_v   = 1'b0;
        win_age = '0;
        win_idx = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_gv[g] && (!win_v || r_gage[g] > win_age)) begin
                win_v   = 1'b1;
                win_age = r_gage[g];
                win_idx = r_gidx[g];
            end
        end
    end

    always_comb begin
        other = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (rdy[i] && SW'(i) != win_idx) begin
                other = 1'b1;
            end
        end
    end

    always_comb begin
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SW'(i);
            end
        end
    end

    assign o_stat.out_free    = !r_ovalid || i_out_ready;
    assign o_stat.is_select   = (r_cmd == iqwos_pkg::CMD_SELECT);
    assign o_stat.found       = win_v;
    assign o_stat.other_ready = other;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd     <= i_command;
            r_in_dest <= i_dest_tag;
            r_in_cls  <= i_op_class;
            r_in_s1   <= i_src1_tag;
            r_in_s1ok <= i_src1_ok;
            r_in_s2   <= i_src2_tag;
            r_in_s2ok <= i_src2_ok;
            r_in_wake <= i_wake_tag;
        end
        if (i_cmd.find) begin
            r_gv   <= n_gv;
            r_gage <= n_gage;
            r_gidx <= n_gidx;
        end
    end

    // Slot payload, ages and ready flags.
    always_ff @(posedge i_clk) begin
        if (do_disp) begin
            r_age[free_idx]  <= '0;
            r_dest[free_idx] <= r_in_dest;
            r_cls[free_idx]  <= r_in_cls;
            r_s1[free_idx]   <= r_in_s1;
            r_s2[free_idx]   <= r_in_s2;
            r_s1ok[free_idx] <= r_in_s1ok;
            r_s2ok[free_idx] <= r_in_s2ok;
        end
        if (i_cmd.exec && r_cmd == iqwos_pkg::CMD_WAKEUP) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (r_valid[i] && r_s1[i] == r_in_wake) begin
                    r_s1ok[i] <= 1'b1;
                end
                if (r_valid[i] && r_s2[i] == r_in_wake) begin
                    r_s2ok[i] <= 1'b1;
                end
            end
        end
        if (i_cmd.age) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (r_valid[i] && r_age[i] != AGE_MAX) begin
                    r_age[i] <= r_age[i] + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_free  <= FW'(QUEUE_DEPTH);
        end else if (do_disp) begin
            r_valid[free_idx] <= 1'b1;
            r_free <= r_free - FW'(1);
        end else if (i_cmd.issue) begin
            r_valid[win_idx] <= 1'b0;
            r_free <= r_free + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.issue || i_cmd.emit_empty) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec || i_cmd.emit_empty) begin
            r_oacc  <= do_disp;
            r_oiv   <= 1'b0;
            r_odest <= '0;
            r_ocls  <= '0;
            r_oslot <= '0;
            r_ofree <= do_disp ? r_free - FW'(1) : r_free;
            r_olast <= 1'b1;
        end else if (i_cmd.issue) begin
            r_oacc  <= 1'b0;
            r_oiv   <= 1'b1;
            r_odest <= r_dest[win_idx];
            r_ocls  <= r_cls[win_idx];
            r_oslot <= win_idx;
            r_ofree <= r_free + FW'(1);
            r_olast <= i_cmd.issue_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_accepted     = r_oacc;
    assign o_issue_valid  = r_oiv;
    assign o_issued_dest  = r_odest;
    assign o_issued_class = r_ocls;
    assign o_issued_slot  = r_oslot;
    assign o_free_count   = r_ofree;
    assign o_last         = r_olast;

endmodule

// ===== src/iqwos_chk.sv =====
// Port-level checks of the issue queue, bound to the top level.
module iqwos_chk #(
    parameter int OUT_W = 24
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser,
    input logic             m_axis_tlast
);

    // One request at a time: the input side closes right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted request");

    a_accept_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tlast && !m_axis_tuser)
        else $error("accepted dispatch result not a single final result");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("result without issue is not final");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind issue_queue_wakeup_oldest_select iqwos_chk #(.OUT_W(OUT_W)) u_iqwos_chk (.*);
